FILE: hdl/mkde_pkg.sv
// Shared types, constants and key tables for the keypad digit entry block.
`timescale 1ns / 1ps

package mkde_pkg;

   // Fixed field widths of the keypad and the digit store.
   localparam int KEY_COUNT    = 16;
   localparam int INDEX_WIDTH  = 4;
   localparam int DIGIT_WIDTH  = 4;
   localparam int COUNT_WIDTH  = 5;
   localparam int STORE_SLOTS  = 16;
   localparam int STORE_WIDTH  = STORE_SLOTS * DIGIT_WIDTH;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CLASS_DIGIT = 2'd0,
      CLASS_SEND  = 2'd1,
      CLASS_END   = 2'd2,
      CLASS_BLANK = 2'd3
   } key_class_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_APPEND = 2'd2
   } action_type;

   // One word passed from the front end to the back end.
   typedef struct packed {
      action_type                action;
      logic [INDEX_WIDTH-1:0]    slot;
      logic [DIGIT_WIDTH-1:0]    digit;
      logic                      key_event;
      logic [INDEX_WIDTH-1:0]    key_index;
      key_class_type             key_class;
      logic [COUNT_WIDTH-1:0]    digit_count;
      logic                      send_flag;
      logic                      stop_flag;
   } word_type;

   // Class of each key, indexed by col*4+row.
   function automatic key_class_type key_kind(input logic [INDEX_WIDTH-1:0] idx);
      key_class_type result;
      case (idx)
         4'd0:                                      result = CLASS_SEND;
         4'd12:                                     result = CLASS_END;
         4'd2, 4'd3, 4'd4, 4'd8:                    result = CLASS_BLANK;
         default:                                   result = CLASS_DIGIT;
      endcase
      return result;
   endfunction

   // Digit value of each digit key; other keys give zero.
   function automatic logic [DIGIT_WIDTH-1:0] key_digit(input logic [INDEX_WIDTH-1:0] idx);
      logic [DIGIT_WIDTH-1:0] result;
      case (idx)
         4'd5:    result = 4'd9;
         4'd6:    result = 4'd6;
         4'd7:    result = 4'd3;
         4'd9:    result = 4'd8;
         4'd10:   result = 4'd5;
         4'd11:   result = 4'd2;
         4'd13:   result = 4'd7;
         4'd14:   result = 4'd4;
         4'd15:   result = 4'd1;
         default: result = 4'd0;
      endcase
      return result;
   endfunction

endpackage

FILE: hdl/mkde_front.sv
// Front end: release edge search, key levels and the entry control flags.
`timescale 1ns / 1ps

module mkde_front #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_accept,
   input  logic                                 command,
   input  logic [mkde_pkg::KEY_COUNT-1:0]       key_pressed_bits,
   output mkde_pkg::word_type                   word
);

   logic [mkde_pkg::KEY_COUNT-1:0]   last_ff, last_in;
   logic [mkde_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                             send_ff, send_in;
   logic                             stop_ff, stop_in;

   logic [mkde_pkg::KEY_COUNT-1:0]   edges, lowest, mask;
   logic [mkde_pkg::INDEX_WIDTH-1:0] idx;
   logic                             found;
   logic                             full;
   mkde_pkg::key_class_type          cls;

   // Lowest release edge and the set of keys examined up to it.
   always_comb begin
      edges  = last_ff & ~key_pressed_bits;
      lowest = edges & (~edges + mkde_pkg::KEY_COUNT'(1));
      found  = |edges;
      mask   = found ? (lowest | (lowest - mkde_pkg::KEY_COUNT'(1))) : '1;
      idx    = '0;
      for (int k = 0; k < mkde_pkg::KEY_COUNT; k++) begin
         if (lowest[k]) begin
            idx = idx | mkde_pkg::INDEX_WIDTH'(k);
         end
      end
      cls  = mkde_pkg::key_kind(idx);
      full = (count_ff >= mkde_pkg::COUNT_WIDTH'(MAX_DIGITS));
   end

   // Decide the action and the flags that follow from this word.
   always_comb begin
      last_in  = last_ff;
      count_in = count_ff;
      send_in  = send_ff;
      stop_in  = stop_ff;

      word             = '0;
      word.action      = mkde_pkg::ACT_NONE;
      word.key_class   = mkde_pkg::CLASS_DIGIT;
      word.slot        = count_ff[mkde_pkg::INDEX_WIDTH-1:0];
      word.digit       = mkde_pkg::key_digit(idx);

      if (command) begin
         word.action = mkde_pkg::ACT_CLEAR;
         count_in    = '0;
         send_in     = 1'b0;
      end else if (!stop_ff) begin
         last_in = (key_pressed_bits & mask) | (last_ff & ~mask);
         if (found) begin
            word.key_event = 1'b1;
            word.key_index = idx;
            word.key_class = cls;
            if (cls == mkde_pkg::CLASS_SEND || full) begin
               send_in = 1'b1;
            end else if (cls == mkde_pkg::CLASS_DIGIT) begin
               word.action = mkde_pkg::ACT_APPEND;
               count_in    = count_ff + mkde_pkg::COUNT_WIDTH'(1);
            end else if (cls == mkde_pkg::CLASS_END) begin
               stop_in = 1'b1;
            end
         end
      end

      word.digit_count = count_in;
      word.send_flag   = send_in;
      word.stop_flag   = stop_in;
   end

   // State is updated only when a word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         count_ff <= '0;
         send_ff  <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (in_accept) begin
         last_ff  <= last_in;
         count_ff <= count_in;
         send_ff  <= send_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

FILE: hdl/mkde_queue.sv
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module mkde_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mkde_pkg::word_type push_word,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output mkde_pkg::word_type pop_word
);

   mkde_pkg::word_type                entry_ff [mkde_pkg::QUEUE_DEPTH];
   logic [mkde_pkg::QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mkde_pkg::QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mkde_pkg::QCOUNT_WIDTH-1:0] fill_ff, fill_in;

   assign not_full  = (fill_ff != mkde_pkg::QCOUNT_WIDTH'(mkde_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_word  = entry_ff[rd_ptr_ff];

   // Pointer wrap and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mkde_pkg::QPTR_WIDTH'(mkde_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mkde_pkg::QPTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mkde_pkg::QPTR_WIDTH'(mkde_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mkde_pkg::QPTR_WIDTH'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + mkde_pkg::QCOUNT_WIDTH'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - mkde_pkg::QCOUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: hdl/mkde_back.sv
// Back end: digit store updates and the registered result word.
`timescale 1ns / 1ps

module mkde_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                word_valid,
   input  mkde_pkg::word_type                  word,
   output logic                                word_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_key_event,
   output logic [mkde_pkg::INDEX_WIDTH-1:0]    rsp_key_index,
   output logic [1:0]                          rsp_key_class,
   output logic [mkde_pkg::COUNT_WIDTH-1:0]    rsp_digit_count,
   output logic                                rsp_send_flag,
   output logic                                rsp_stop_flag,
   output logic [mkde_pkg::STORE_WIDTH-1:0]    rsp_digits_packed
);

   logic [mkde_pkg::STORE_WIDTH-1:0] store_ff, store_in;
   logic                             valid_ff;
   mkde_pkg::word_type               out_ff;

   // Take a new word whenever the output register is free or being emptied.
   assign word_pop = word_valid && (!valid_ff || rsp_ready);

   // Slots beyond the count stay zero, so the store is the packed result.
   always_comb begin
      store_in = store_ff;
      case (word.action)
         mkde_pkg::ACT_CLEAR: begin
            store_in = '0;
         end
         mkde_pkg::ACT_APPEND: begin
            for (int s = 0; s < mkde_pkg::STORE_SLOTS; s++) begin
               if (word.slot == mkde_pkg::INDEX_WIDTH'(s)) begin
                  store_in[s*mkde_pkg::DIGIT_WIDTH +: mkde_pkg::DIGIT_WIDTH] = word.digit;
               end
            end
         end
         default: begin
            store_in = store_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         store_ff <= '0;
      end else begin
         if (word_pop) begin
            valid_ff <= 1'b1;
            store_ff <= store_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (word_pop) begin
         out_ff            <= word;
         rsp_digits_packed <= store_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_key_event   = out_ff.key_event;
   assign rsp_key_index   = out_ff.key_index;
   assign rsp_key_class   = out_ff.key_class;
   assign rsp_digit_count = out_ff.digit_count;
   assign rsp_send_flag   = out_ff.send_flag;
   assign rsp_stop_flag   = out_ff.stop_flag;

endmodule

FILE: hdl/matrix_keypad_digit_entry_core.sv
// Top level of the 4x4 keypad digit entry block.
`timescale 1ns / 1ps

// Each request word is either a scan sample of the 16 key levels or a clear
// command, and every request word gives exactly one response word. A word is
// accepted every cycle while the queue has room: the front end finds the first
// press-to-release edge, updates the key levels and the count, send and stop
// flags in the cycle of acceptance, and the back end writes the digit store
// and loads the response register when it takes the word from the queue. A
// two-entry queue between the halves and the response register let the
// request side keep flowing while a response waits.

module matrix_keypad_digit_entry_core #(
   parameter int MAX_DIGITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_key_pressed_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_key_event,
   output logic [3:0]  rsp_key_index,
   output logic [1:0]  rsp_key_class,
   output logic [4:0]  rsp_digit_count,
   output logic        rsp_send_flag,
   output logic        rsp_stop_flag,
   output logic [63:0] rsp_digits_packed
);

   mkde_pkg::word_type front_word;
   mkde_pkg::word_type back_word;
   logic               in_accept;
   logic               q_not_full;
   logic               q_not_empty;
   logic               q_pop;

   assign req_ready = q_not_full;
   assign in_accept = req_valid && q_not_full;

   mkde_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (in_accept),
      .command          (req_command),
      .key_pressed_bits (req_key_pressed_bits),
      .word             (front_word)
   );

   mkde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (in_accept),
      .push_word (front_word),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_word  (back_word)
   );

   mkde_back u_back (
      .clock             (clock),
      .reset             (reset),
      .word_valid        (q_not_empty),
      .word              (back_word),
      .word_pop          (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_event     (rsp_key_event),
      .rsp_key_index     (rsp_key_index),
      .rsp_key_class     (rsp_key_class),
      .rsp_digit_count   (rsp_digit_count),
      .rsp_send_flag     (rsp_send_flag),
      .rsp_stop_flag     (rsp_stop_flag),
      .rsp_digits_packed (rsp_digits_packed)
   );

endmodule

FILE: hdl/mkde_checker.sv
// Port-level checks for the keypad digit entry block and their binding.
`timescale 1ns / 1ps

module mkde_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_key_event,
   input logic [3:0]  rsp_key_index,
   input logic [1:0]  rsp_key_class,
   input logic [4:0]  rsp_digit_count,
   input logic        rsp_send_flag,
   input logic        rsp_stop_flag,
   input logic [63:0] rsp_digits_packed
);

   // A stalled response word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_event) &&
      $stable(rsp_key_index) && $stable(rsp_key_class) && $stable(rsp_digit_count) &&
      $stable(rsp_send_flag) && $stable(rsp_stop_flag) && $stable(rsp_digits_packed))
      else $error("stalled response word changed");

   // No response is offered in the first cycle after reset is released.
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   // Index and class are zero unless a release was seen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_key_event |-> rsp_key_index == 4'd0 && rsp_key_class == 2'd0)
      else $error("key fields set without a key event");

   // An empty store packs to zero, and the count never exceeds the store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count <= 5'd16 &&
      (rsp_digit_count != 5'd0 || rsp_digits_packed == 64'd0))
      else $error("digit count and packed digits disagree");

endmodule

bind matrix_keypad_digit_entry_core mkde_checker u_mkde_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_key_event     (rsp_key_event),
   .rsp_key_index     (rsp_key_index),
   .rsp_key_class     (rsp_key_class),
   .rsp_digit_count   (rsp_digit_count),
   .rsp_send_flag     (rsp_send_flag),
   .rsp_stop_flag     (rsp_stop_flag),
   .rsp_digits_packed (rsp_digits_packed)
);
